FILE: rtl/four_channel_peak_position_macros.svh
// Assertion shorthands used by the checker of this block.
`ifndef FOUR_CHANNEL_PEAK_POSITION_MACROS_SVH
`define FOUR_CHANNEL_PEAK_POSITION_MACROS_SVH

// Check that a condition implies another in the same cycle.
`define FCPP_ASSERT_SAME(lbl, clk, rst_n, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error("fcpp check failed");

// Check that a condition implies another in the next cycle.
`define FCPP_ASSERT_NEXT(lbl, clk, rst_n, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error("fcpp check failed");

`endif

FILE: rtl/fcpp_pkg.sv
package fcpp_pkg;

  // Fixed field widths of the item channels
  localparam int SAMPLE_W  = 14;
  localparam int LIMIT_W   = 16;
  localparam int POS_W     = 16;
  localparam int CFG_IDX_W = 1;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_SUM_LOW  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SUM_HIGH = 1'd1;

  // Register reset values
  localparam logic [LIMIT_W-1:0] SUM_LOW_RESET  = 16'd220;
  localparam logic [LIMIT_W-1:0] SUM_HIGH_RESET = 16'd40000;

  typedef struct packed {
    logic [SAMPLE_W-1:0] sample_a;
    logic [SAMPLE_W-1:0] sample_b;
    logic [SAMPLE_W-1:0] sample_c;
    logic [SAMPLE_W-1:0] sample_d;
    logic                last_sample;
  } in_item_t;

  typedef struct packed {
    logic [LIMIT_W-1:0]      peak_sum;
    logic signed [POS_W-1:0] pos_x;
    logic signed [POS_W-1:0] pos_y;
    logic                    in_window;
    logic                    zero_denominator;
  } out_item_t;

endpackage

FILE: rtl/fcpp_if.sv
// Sample channel into the block
interface fcpp_in_if;
  logic               valid;
  logic               ready;
  fcpp_pkg::in_item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// Event result channel out of the block
interface fcpp_out_if;
  logic                valid;
  logic                ready;
  fcpp_pkg::out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

FILE: rtl/fcpp_peak_track.sv
module fcpp_peak_track #(
  parameter int SAMPLE_BITS = 14
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        upd_i,
  input  logic                        clr_i,
  input  logic [3:0][SAMPLE_BITS-1:0] smp_i,
  output logic [3:0][SAMPLE_BITS-1:0] fold_o
);

  logic [3:0][SAMPLE_BITS-1:0] peak_q;
  logic [3:0][SAMPLE_BITS-1:0] peak_d;

  // Fold the current samples into the running peaks
  always_comb begin
    for (int ch = 0; ch < 4; ch++) begin
      fold_o[ch] = (smp_i[ch] > peak_q[ch]) ? smp_i[ch] : peak_q[ch];
    end
  end

  // Advance on an accepted item, drop everything at the end of an event
  always_comb begin
    peak_d = peak_q;
    if (upd_i) begin
      peak_d = clr_i ? '0 : fold_o;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      peak_q <= '0;
    end else begin
      peak_q <= peak_d;
    end
  end

endmodule

FILE: rtl/fcpp_serial_div.sv
module fcpp_serial_div #(
  parameter int SAMPLE_BITS   = 14,
  parameter int FRACTION_BITS = 15
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 start_i,
  input  logic [SAMPLE_BITS-1:0]               num_a_i,
  input  logic [SAMPLE_BITS-1:0]               num_b_i,
  output logic                                 done_o,
  output logic signed [fcpp_pkg::POS_W-1:0]    pos_o,
  output logic                                 zero_o
);

  localparam int DEN_W = SAMPLE_BITS + 1;
  localparam int QW    = FRACTION_BITS + 1;
  localparam int QX    = (QW > 17) ? QW : 17;
  localparam int CNT_W = $clog2(QW + 1);
  localparam int POS_LIMIT = 32767;
  localparam int NEG_LIMIT = 32768;

  logic             busy_q;
  logic             done_q;
  logic [CNT_W-1:0] cnt_q;
  logic             neg_q;
  logic             zero_q;
  logic [DEN_W-1:0] den_q;
  logic [DEN_W:0]   rem_q;
  logic [QW-1:0]    quo_q;

  logic [DEN_W-1:0]       den_start;
  logic [SAMPLE_BITS-1:0] mag_start;
  logic                   rem_ge;
  logic [DEN_W:0]         rem_sub;
  logic [QX-1:0]          quo_x;
  logic [QX-1:0]          quo_sat;
  logic [fcpp_pkg::POS_W-1:0] mag16;

  // Operands of (a - b) / (a + b) as magnitude and sign
  assign den_start = DEN_W'(num_a_i) + DEN_W'(num_b_i);
  assign mag_start = (num_a_i >= num_b_i) ? (num_a_i - num_b_i) : (num_b_i - num_a_i);

  // One restoring step: trial subtract, keep the quotient bit
  assign rem_ge  = (rem_q >= {1'b0, den_q});
  assign rem_sub = rem_ge ? (rem_q - {1'b0, den_q}) : rem_q;

  // Sequence the quotient bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CNT_W'(QW);
      end else if (busy_q) begin
        cnt_q <= cnt_q - CNT_W'(1);
        if (cnt_q == CNT_W'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // Shift the remainder and quotient one bit per cycle
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      den_q  <= den_start;
      rem_q  <= (DEN_W + 1)'(mag_start);
      neg_q  <= (num_a_i < num_b_i);
      zero_q <= (den_start == '0);
    end else if (busy_q) begin
      rem_q <= {rem_sub[DEN_W-1:0], 1'b0};
      quo_q <= {quo_q[QW-2:0], rem_ge};
    end
  end

  // Saturate to Q1.15 and apply the sign
  always_comb begin
    quo_x = QX'(quo_q);
    if (neg_q) begin
      quo_sat = (quo_x > QX'(NEG_LIMIT)) ? QX'(NEG_LIMIT) : quo_x;
    end else begin
      quo_sat = (quo_x > QX'(POS_LIMIT)) ? QX'(POS_LIMIT) : quo_x;
    end
    mag16 = quo_sat[fcpp_pkg::POS_W-1:0];
    if (zero_q) begin
      pos_o = '0;
    end else if (neg_q) begin
      pos_o = $signed(-mag16);
    end else begin
      pos_o = $signed(mag16);
    end
  end

  assign done_o = done_q;
  assign zero_o = zero_q;

endmodule

FILE: rtl/four_channel_peak_position.sv
// Four-channel peak detector with Anger-style position readout. Items without
// the last-sample mark only update the per-channel peaks and are taken one per
// clock. An item with the mark closes the event: its samples are folded into
// the peaks, the peaks clear, and two bit-serial restoring dividers work out
// x and y, one quotient bit per cycle, so the input stays stalled until both
// dividers are done and the result is loaded. The result then sits in an
// output register while new samples are taken. The user must write the sum
// limits through the cfg port while no event is in flight; this is not enforced.
module four_channel_peak_position #(
  parameter int SAMPLE_BITS   = 14,
  parameter int FRACTION_BITS = 15
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  fcpp_in_if.sink                             in_i,
  fcpp_out_if.source                          out_o,
  input  logic                                cfg_we_i,
  input  logic [fcpp_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [fcpp_pkg::LIMIT_W-1:0]        cfg_wdata_i
);

  localparam int SUM_W = SAMPLE_BITS + 2;
  localparam int CMP_W = (SUM_W > 17) ? SUM_W : 17;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_DIV  = 2'd1;
  localparam logic [1:0] ST_HOLD = 2'd2;

  logic [1:0] state_q, state_d;

  logic [fcpp_pkg::LIMIT_W-1:0] low_q;
  logic [fcpp_pkg::LIMIT_W-1:0] high_q;

  logic [3:0][SAMPLE_BITS-1:0] smp;
  logic [3:0][SAMPLE_BITS-1:0] fold;
  logic                        in_fire;
  logic                        ev_start;

  logic [SUM_W-1:0] sum_q;
  logic [CMP_W-1:0] sum_x;

  logic                              done_x, done_y, div_done;
  logic                              zero_x, zero_y;
  logic signed [fcpp_pkg::POS_W-1:0] pos_x, pos_y;

  logic                out_valid_q, out_valid_d;
  fcpp_pkg::out_item_t out_data_q;
  fcpp_pkg::out_item_t res;
  logic                slot_free;
  logic                load;

  // Mask samples to the peak width
  assign smp[0] = SAMPLE_BITS'(in_i.data.sample_a);
  assign smp[1] = SAMPLE_BITS'(in_i.data.sample_b);
  assign smp[2] = SAMPLE_BITS'(in_i.data.sample_c);
  assign smp[3] = SAMPLE_BITS'(in_i.data.sample_d);

  assign in_i.ready = (state_q == ST_IDLE);
  assign in_fire    = in_i.valid && in_i.ready;
  assign ev_start   = in_fire && in_i.data.last_sample;

  fcpp_peak_track #(
    .SAMPLE_BITS(SAMPLE_BITS)
  ) u_peak (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .upd_i (in_fire),
    .clr_i (in_i.data.last_sample),
    .smp_i (smp),
    .fold_o(fold)
  );

  fcpp_serial_div #(
    .SAMPLE_BITS  (SAMPLE_BITS),
    .FRACTION_BITS(FRACTION_BITS)
  ) u_div_x (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(ev_start),
    .num_a_i(fold[0]),
    .num_b_i(fold[1]),
    .done_o (done_x),
    .pos_o  (pos_x),
    .zero_o (zero_x)
  );

  // y = -(p2 - p3) / (p2 + p3), taken as (p3 - p2) / (p3 + p2)
  fcpp_serial_div #(
    .SAMPLE_BITS  (SAMPLE_BITS),
    .FRACTION_BITS(FRACTION_BITS)
  ) u_div_y (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(ev_start),
    .num_a_i(fold[3]),
    .num_b_i(fold[2]),
    .done_o (done_y),
    .pos_o  (pos_y),
    .zero_o (zero_y)
  );

  assign div_done = done_x && done_y;

  // Hold the peak sum of the closing event
  always_ff @(posedge clk_i) begin
    if (ev_start) begin
      sum_q <= SUM_W'(fold[0]) + SUM_W'(fold[1]) + SUM_W'(fold[2]) + SUM_W'(fold[3]);
    end
  end

  // Assemble the result item
  always_comb begin
    sum_x            = CMP_W'(sum_q);
    res.peak_sum     = (sum_x > CMP_W'(16'hFFFF)) ? 16'hFFFF
                                                   : sum_x[fcpp_pkg::LIMIT_W-1:0];
    res.pos_x        = pos_x;
    res.pos_y        = pos_y;
    res.in_window    = (sum_x > CMP_W'(low_q)) && (sum_x < CMP_W'(high_q));
    res.zero_denominator = zero_x || zero_y;
  end

  assign slot_free = !out_valid_q || out_o.ready;
  assign load      = ((state_q == ST_DIV && div_done) || state_q == ST_HOLD) && slot_free;

  // Sequence one event at a time
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (ev_start) state_d = ST_DIV;
      end
      ST_DIV: begin
        if (div_done) state_d = slot_free ? ST_IDLE : ST_HOLD;
      end
      ST_HOLD: begin
        if (slot_free) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (load) begin
      out_valid_d = 1'b1;
    end else if (out_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      out_data_q <= res;
    end
  end

  assign out_o.valid = out_valid_q;
  assign out_o.data  = out_data_q;

  // Write the sum limits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      low_q  <= fcpp_pkg::SUM_LOW_RESET;
      high_q <= fcpp_pkg::SUM_HIGH_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        fcpp_pkg::REG_SUM_LOW:  low_q  <= cfg_wdata_i;
        fcpp_pkg::REG_SUM_HIGH: high_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

endmodule

FILE: rtl/fcpp_checker.sv
`include "four_channel_peak_position_macros.svh"

module fcpp_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_valid_i,
  input logic                in_ready_i,
  input logic                in_last_i,
  input logic                out_valid_i,
  input logic                out_ready_i,
  input fcpp_pkg::out_item_t out_data_i
);

  // Hold a stalled result item
  `FCPP_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_i && !out_ready_i, out_valid_i)
  `FCPP_ASSERT_NEXT(a_out_stable, clk_i, rst_ni, out_valid_i && !out_ready_i, $stable(out_data_i))
  // Stall input while an event is being divided
  `FCPP_ASSERT_NEXT(a_busy_after_last, clk_i, rst_ni, in_valid_i && in_ready_i && in_last_i, !in_ready_i)
  // An all-zero event has no position
  `FCPP_ASSERT_SAME(a_zero_event, clk_i, rst_ni, out_valid_i && out_data_i.peak_sum == 16'd0, out_data_i.zero_denominator && out_data_i.pos_x == 16'sd0 && out_data_i.pos_y == 16'sd0)

endmodule

bind four_channel_peak_position fcpp_checker u_fcpp_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .in_valid_i (in_i.valid),
  .in_ready_i (in_i.ready),
  .in_last_i  (in_i.data.last_sample),
  .out_valid_i(out_o.valid),
  .out_ready_i(out_o.ready),
  .out_data_i (out_o.data)
);
